[hw/rtl/msic_pkg.sv]
package msic_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int DATA_W    = 32;
	localparam int INV_W     = 11;
	localparam int ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int EXT_W     = CNT_W + 2;
	localparam int SUM_W     = ((INV_W > CNT_W) ? INV_W : CNT_W) + 1;
	localparam logic [INV_W-1:0] INV_MAX = {INV_W{1'b1}};

	// one write port, two read ports
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr0;
		logic [ADDR_W-1:0] raddr1;
	} ram_req_t;

endpackage

[hw/rtl/msic_if.sv]
interface msic_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [msic_pkg::DATA_W-1:0] sample;
	logic                              final_item;

	modport source(output valid, sample, final_item, input ready);
	modport sink(input valid, sample, final_item, output ready);
endinterface

interface msic_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [msic_pkg::DATA_W-1:0] sorted_value;
	logic [msic_pkg::INV_W-1:0]         inversions;
	logic                              overflow;
	logic                              last_out;

	modport source(output valid, sorted_value, inversions, overflow, last_out, input ready);
	modport sink(input valid, sorted_value, inversions, overflow, last_out, output ready);
endinterface

[hw/rtl/msic_ram.sv]
module msic_ram (
	input  logic                        clk,
	input  msic_pkg::ram_req_t          req,
	output logic [msic_pkg::DATA_W-1:0] rd0,
	output logic [msic_pkg::DATA_W-1:0] rd1
);

	logic [msic_pkg::DATA_W-1:0] mem [msic_pkg::MAX_ITEMS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rd0 <= mem[req.raddr0];
		rd1 <= mem[req.raddr1];
	end

endmodule

[hw/rtl/merge_sort_inversion_count_unit.sv]
// channel   modport  fields                                          role
// samples   sink     sample, final_item                              elements of one set
// results   source   sorted_value, inversions, overflow, last_out    sorted burst
//
// loading fills memory a; a set of n items then runs ceil(log2 n) merge passes,
// each a setup step and then one compare and one write per cycle (bounded by the
// single write port of the destination memory); each burst item is read, then loaded
// arst_n clears all control state; the two memories are never cleared, only
// entries below the element count are read
// results are held in an output register while the sink stalls; samples are taken
// again once the last result sits in that register

module merge_sort_inversion_count_unit (
	input  logic       clk,
	input  logic       arst_n,
	msic_in_if.sink    samples,
	msic_out_if.source results
);

	localparam int CNT_W  = msic_pkg::CNT_W;
	localparam int EXT_W  = msic_pkg::EXT_W;
	localparam int SUM_W  = msic_pkg::SUM_W;
	localparam int ADDR_W = msic_pkg::ADDR_W;
	localparam int DATA_W = msic_pkg::DATA_W;
	localparam int INV_W  = msic_pkg::INV_W;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SETUP,
		ST_MERGE,
		ST_OUT_RD,
		ST_OUT_LD
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;   // elements held, n while sorting
	logic [CNT_W-1:0]     w_q;       // run width of the current pass
	logic [CNT_W-1:0]     mid_q;
	logic [CNT_W-1:0]     hi_q;
	logic [CNT_W-1:0]     i_q;       // left run head
	logic [CNT_W-1:0]     j_q;       // right run head
	logic [CNT_W-1:0]     k_q;       // write position
	logic [CNT_W-1:0]     o_q;       // burst position
	logic [INV_W-1:0]     inv_q;
	logic                 ovf_q;
	logic                 src_sel_q; // 0: memory a holds the runs, 1: memory b

	logic                 out_valid_q;
	logic [DATA_W-1:0]    out_value_q;
	logic [INV_W-1:0]     out_inv_q;
	logic                 out_ovf_q;
	logic                 out_last_q;

	msic_pkg::ram_req_t   req_a, req_b;
	logic [DATA_W-1:0]    a_rd0, a_rd1, b_rd0, b_rd1;
	logic [DATA_W-1:0]    src_rd0, src_rd1;

	// clamp a run bound to the element count
	function automatic logic [CNT_W-1:0] clamp_n(input logic [EXT_W-1:0] v,
		input logic [CNT_W-1:0] n);
		clamp_n = (v > EXT_W'(n)) ? n : v[CNT_W-1:0];
	endfunction

	msic_ram u_ram_a (.clk(clk), .req(req_a), .rd0(a_rd0), .rd1(a_rd1));
	msic_ram u_ram_b (.clk(clk), .req(req_b), .rd0(b_rd0), .rd1(b_rd1));

	assign src_rd0 = src_sel_q ? b_rd0 : a_rd0;
	assign src_rd1 = src_sel_q ? b_rd1 : a_rd1;

	// input side
	logic             in_acc;
	logic             out_acc;
	logic             store_full;
	logic [CNT_W-1:0] count_inc;
	logic [CNT_W-1:0] n_new;

	assign samples.ready = (state_q == ST_LOAD);
	assign in_acc        = samples.valid && samples.ready;
	assign out_acc       = results.valid && results.ready;
	assign store_full    = (count_q == CNT_W'(msic_pkg::MAX_ITEMS));
	assign count_inc     = count_q + CNT_W'(1);
	assign n_new         = store_full ? count_q : count_inc;

	// one merge step: compare the two run heads and emit the smaller
	logic             left_ok, right_ok, take_left;
	logic [CNT_W-1:0] inv_add;
	logic [SUM_W-1:0] inv_sum;
	logic [INV_W-1:0] inv_next;
	logic [CNT_W-1:0] k_inc;
	logic             blk_end, pass_end;
	logic [EXT_W-1:0] w_dbl;
	logic             sort_done;
	logic [CNT_W-1:0] nblk_mid, nblk_hi;
	logic [CNT_W-1:0] pass_mid, pass_hi;
	logic [CNT_W-1:0] i_d, j_d;
	logic [DATA_W-1:0] merge_data;

	always_comb begin
		left_ok    = (i_q < mid_q);
		right_ok   = (j_q < hi_q);
		// ties take the left run, which keeps the sort stable
		take_left  = left_ok && (!right_ok || ($signed(src_rd0) <= $signed(src_rd1)));
		merge_data = take_left ? src_rd0 : src_rd1;
		// every element still in the left run forms an inversion with the right head
		inv_add    = (left_ok && !take_left) ? (mid_q - i_q) : '0;
		inv_sum    = SUM_W'(inv_q) + SUM_W'(inv_add);
		inv_next   = (inv_sum > SUM_W'(msic_pkg::INV_MAX)) ? msic_pkg::INV_MAX
			: inv_sum[INV_W-1:0];
		k_inc      = k_q + CNT_W'(1);
		blk_end    = (k_inc == hi_q);
		pass_end   = blk_end && (hi_q == count_q);
		nblk_mid   = clamp_n(EXT_W'(hi_q) + EXT_W'(w_q), count_q);
		nblk_hi    = clamp_n(EXT_W'(hi_q) + (EXT_W'(w_q) << 1), count_q);
		w_dbl      = EXT_W'(w_q) << 1;
		sort_done  = (w_dbl >= EXT_W'(count_q));
		pass_mid   = clamp_n(w_dbl, count_q);
		pass_hi    = clamp_n(w_dbl << 1, count_q);
		if (blk_end) begin
			i_d = hi_q;
			j_d = nblk_mid;
		end else begin
			i_d = i_q + CNT_W'(take_left);
			j_d = j_q + CNT_W'(!take_left);
		end
	end

	// memory port routing: runs are read from the source, written to the other one
	logic              dst_we;
	logic [ADDR_W-1:0] rd_addr0, rd_addr1;
	msic_pkg::ram_req_t src_req, dst_req;

	always_comb begin
		dst_we   = 1'b0;
		rd_addr0 = '0;
		rd_addr1 = '0;
		unique case (state_q)
			ST_LOAD: begin
			end
			ST_SETUP: begin
				rd_addr0 = i_q[ADDR_W-1:0];
				rd_addr1 = j_q[ADDR_W-1:0];
			end
			ST_MERGE: begin
				dst_we   = 1'b1;
				rd_addr0 = i_d[ADDR_W-1:0];
				rd_addr1 = j_d[ADDR_W-1:0];
			end
			ST_OUT_RD, ST_OUT_LD: begin
				rd_addr0 = o_q[ADDR_W-1:0];
			end
			default: begin
			end
		endcase

		src_req        = '0;
		src_req.raddr0 = rd_addr0;
		src_req.raddr1 = rd_addr1;
		dst_req        = '0;
		dst_req.we     = dst_we;
		dst_req.waddr  = k_q[ADDR_W-1:0];
		dst_req.wdata  = merge_data;

		if (state_q == ST_LOAD) begin
			// loading always fills memory a
			req_a        = '0;
			req_a.we     = in_acc && !store_full;
			req_a.waddr  = count_q[ADDR_W-1:0];
			req_a.wdata  = samples.sample;
			req_b        = '0;
		end else if (src_sel_q) begin
			req_a = dst_req;
			req_b = src_req;
		end else begin
			req_a = src_req;
			req_b = dst_req;
		end
	end

	logic out_free;
	logic out_load;
	assign out_free = !out_valid_q || results.ready;
	// a new result enters the output register
	assign out_load = (state_q == ST_OUT_LD) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			w_q         <= '0;
			mid_q       <= '0;
			hi_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			o_q         <= '0;
			inv_q       <= '0;
			ovf_q       <= 1'b0;
			src_sel_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_inv_q   <= '0;
			out_ovf_q   <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !out_acc);
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						count_q <= n_new;
						if (store_full) begin
							ovf_q <= 1'b1;
						end
						if (samples.final_item) begin
							// first pass merges runs of one
							inv_q     <= '0;
							src_sel_q <= 1'b0;
							w_q       <= CNT_W'(1);
							i_q       <= '0;
							k_q       <= '0;
							o_q       <= '0;
							mid_q     <= clamp_n(EXT_W'(1), n_new);
							j_q       <= clamp_n(EXT_W'(1), n_new);
							hi_q      <= clamp_n(EXT_W'(2), n_new);
							state_q   <= (n_new == CNT_W'(1)) ? ST_OUT_RD : ST_SETUP;
						end
					end
				end
				ST_SETUP: begin
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					inv_q <= inv_next;
					if (pass_end) begin
						src_sel_q <= !src_sel_q;
						w_q       <= w_dbl[CNT_W-1:0];
						i_q       <= '0;
						k_q       <= '0;
						mid_q     <= pass_mid;
						j_q       <= pass_mid;
						hi_q      <= pass_hi;
						state_q   <= sort_done ? ST_OUT_RD : ST_SETUP;
					end else begin
						i_q <= i_d;
						j_q <= j_d;
						k_q <= k_inc;
						if (blk_end) begin
							mid_q <= nblk_mid;
							hi_q  <= nblk_hi;
						end
					end
				end
				ST_OUT_RD: begin
					state_q <= ST_OUT_LD;
				end
				ST_OUT_LD: begin
					if (out_free) begin
						out_value_q <= src_rd0;
						out_inv_q   <= inv_q;
						out_ovf_q   <= ovf_q;
						out_last_q  <= (o_q == count_q - CNT_W'(1));
						if (o_q == count_q - CNT_W'(1)) begin
							// set done, ready for the next one
							count_q   <= '0;
							ovf_q     <= 1'b0;
							src_sel_q <= 1'b0;
							state_q   <= ST_LOAD;
						end else begin
							o_q     <= o_q + CNT_W'(1);
							state_q <= ST_OUT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign results.valid        = out_valid_q;
	assign results.sorted_value = out_value_q;
	assign results.inversions   = out_inv_q;
	assign results.overflow     = out_ovf_q;
	assign results.last_out     = out_last_q;

endmodule

[hw/rtl/msic_checker.sv]
module msic_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        in_final,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        out_last,
	input logic [msic_pkg::DATA_W-1:0] out_value,
	input logic [msic_pkg::INV_W-1:0]  out_inversions
);

	logic                        have_prev_q;
	logic [msic_pkg::DATA_W-1:0] prev_value_q;
	logic [msic_pkg::INV_W-1:0]  prev_inv_q;

	// last item taken within the current burst
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q  <= 1'b0;
			prev_value_q <= '0;
			prev_inv_q   <= '0;
		end else if (out_valid && out_ready) begin
			have_prev_q  <= !out_last;
			prev_value_q <= out_value;
			prev_inv_q   <= out_inversions;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_no_load_mid_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("samples taken while a burst is in flight");

	a_sort_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_final |=> !in_ready)
		else $error("final item did not start the sort");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && have_prev_q |-> $signed(out_value) >= $signed(prev_value_q))
		else $error("burst not in ascending order");

	a_inv_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && have_prev_q |-> out_inversions == prev_inv_q)
		else $error("inversion count changed within a burst");

endmodule

bind merge_sort_inversion_count_unit msic_checker u_msic_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(samples.valid),
	.in_ready(samples.ready),
	.in_final(samples.final_item),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.out_last(results.last_out),
	.out_value(results.sorted_value),
	.out_inversions(results.inversions)
);

[bench/merge_sort_inversion_count_unit_test.sv]
module merge_sort_inversion_count_unit_test;

	typedef logic signed [msic_pkg::DATA_W-1:0] sample_t;

	// one element of the sorted burst as it should appear on the results channel
	typedef struct packed {
		sample_t                     value;
		logic [msic_pkg::INV_W-1:0]  inversions;
		logic                        overflow;
		logic                        last_out;
	} sorted_entry_t;

	localparam sample_t MIN_SAMPLE = 32'sh8000_0000;
	localparam sample_t MAX_SAMPLE = 32'sh7fff_ffff;

	// value styles for a random set
	typedef enum int {
		STYLE_WIDE,
		STYLE_NARROW,
		STYLE_EDGY
	} value_style_t;

	localparam int RANDOM_ITEMS   = 255;
	localparam int HOLD_CYCLES    = 300;
	localparam int HOLD_AFTER     = 30;
	localparam int DRAIN_CYCLES   = 100;
	localparam int LIMIT_CYCLES   = 200000;

	// mirrors the set being loaded and predicts the burst that the last item starts
	class sort_scoreboard;
		sample_t                    held[msic_pkg::MAX_ITEMS];
		int unsigned                held_count;
		logic                       dropped;
		logic [msic_pkg::INV_W-1:0] inversion_total;
		sorted_entry_t              expected_sorted[$];
		int unsigned                errors;

		function new();
			held_count      = 0;
			dropped         = 1'b0;
			inversion_total = '0;
			errors          = 0;
		endfunction

		// bottom-up stable merge sort of the held set, returns the inversion count
		function int unsigned sort_held(int unsigned n);
			sample_t     scratch[msic_pkg::MAX_ITEMS];
			int unsigned width, lo, mid, hi, i, j, k, inv;
			inv = 0;
			for (width = 1; width < n; width = width * 2) begin
				for (lo = 0; lo + width < n; lo = lo + 2 * width) begin
					mid = lo + width;
					hi  = (mid + width > n) ? n : mid + width;
					i   = lo;
					j   = mid;
					for (k = lo; k < hi; k++) begin
						if (i < mid && (j >= hi || held[i] <= held[j])) begin
							scratch[k] = held[i];
							i++;
						end else begin
							// every element still left in the lower run is greater
							if (i < mid)
								inv += mid - i;
							scratch[k] = held[j];
							j++;
						end
					end
					for (k = lo; k < hi; k++)
						held[k] = scratch[k];
				end
			end
			return inv;
		endfunction

		function void note_sample(sample_t value, logic final_item);
			int unsigned   inv;
			sorted_entry_t entry;
			if (held_count < msic_pkg::MAX_ITEMS) begin
				held[held_count] = value;
				held_count++;
			end else begin
				dropped = 1'b1;
			end
			if (final_item) begin
				inv = sort_held(held_count);
				inversion_total = (inv > msic_pkg::INV_MAX) ? msic_pkg::INV_MAX
					: inv[msic_pkg::INV_W-1:0];
				for (int unsigned k = 0; k < held_count; k++) begin
					entry.value      = held[k];
					entry.inversions = inversion_total;
					entry.overflow   = dropped;
					entry.last_out   = (k + 1 == held_count);
					expected_sorted.push_back(entry);
				end
				held_count = 0;
				dropped    = 1'b0;
			end
		endfunction

		function void check_result(sorted_entry_t got);
			sorted_entry_t want;
			if (expected_sorted.size() == 0) begin
				$error("unexpected result: sorted_value %0d inversions %0d",
					got.value, got.inversions);
				errors++;
				return;
			end
			want = expected_sorted.pop_front();
			if (got.value !== want.value) begin
				$error("sorted_value: expected %0d, actual %0d", want.value, got.value);
				errors++;
			end
			if (got.inversions !== want.inversions) begin
				$error("inversions: expected %0d, actual %0d",
					want.inversions, got.inversions);
				errors++;
			end
			if (got.overflow !== want.overflow) begin
				$error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
				errors++;
			end
			if (got.last_out !== want.last_out) begin
				$error("last_out: expected %0b, actual %0b", want.last_out, got.last_out);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return expected_sorted.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	msic_in_if  samples_ch();
	msic_out_if results_ch();

	merge_sort_inversion_count_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_ch),
		.results(results_ch)
	);

	sort_scoreboard sb = new();

	int unsigned results_seen = 0;
	bit          sender_bursty;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit, far above the slowest legal run
	initial begin
		#(12 * LIMIT_CYCLES);
		$display("TB_ERROR");
		$finish;
	end

	// both channels are observed at the edge, before any driver update lands
	always @(posedge clk) begin
		if (arst_n) begin
			if (samples_ch.valid && samples_ch.ready)
				sb.note_sample(samples_ch.sample, samples_ch.final_item);
			if (results_ch.valid && results_ch.ready) begin
				sb.check_result('{results_ch.sorted_value, results_ch.inversions,
					results_ch.overflow, results_ch.last_out});
				results_seen++;
			end
		end
	end

	// one sample item; valid stays high across back-to-back items
	task automatic send_item(input sample_t value, input logic final_item);
		int unsigned gap;
		gap = sender_bursty ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			samples_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples_ch.valid      <= 1'b1;
		samples_ch.sample     <= value;
		samples_ch.final_item <= final_item;
		@(posedge clk);
		while (!samples_ch.ready) @(posedge clk);
	endtask

	// a whole set, the last item flagged
	task automatic send_set(input sample_t set_q[$]);
		sender_bursty = ($urandom_range(0, 3) == 0);
		foreach (set_q[k])
			send_item(set_q[k], k == set_q.size() - 1);
	endtask

	function automatic sample_t draw_sample(value_style_t style);
		sample_t v;
		case (style)
			STYLE_NARROW: begin
				// tight range so that equal values are common
				v = $signed($urandom_range(0, 8)) - 4;
			end
			STYLE_EDGY: begin
				case ($urandom_range(0, 4))
					0: v = MIN_SAMPLE;
					1: v = MAX_SAMPLE;
					2: v = 0;
					3: v = -1;
					default: v = $urandom;
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// receiver: random stalls, stall-free stretches and one long hold-off
	initial begin
		int unsigned  gap;
		int unsigned  since_switch;
		bit           calm;
		bit           held_off;
		since_switch = 0;
		calm         = 1'b0;
		held_off     = 1'b0;
		results_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!held_off && results_seen >= HOLD_AFTER) begin
				// sender keeps offering, the block fills up and stalls its input
				held_off = 1'b1;
				results_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (since_switch >= 16) begin
				since_switch = 0;
				calm = ($urandom_range(0, 2) == 0);
			end
			gap = calm ? 0 : $urandom_range(0, 4);
			if (gap > 0) begin
				results_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			results_ch.ready <= 1'b1;
			@(posedge clk);
			while (!results_ch.valid) @(posedge clk);
			since_switch++;
		end
	end

	// stimulus and end of run
	initial begin
		sample_t      set_q[$];
		int unsigned  sent;
		int unsigned  set_size;
		int unsigned  kind;
		int unsigned  set_index;
		value_style_t style;

		sender_bursty = 1'b0;
		samples_ch.valid      <= 1'b0;
		samples_ch.sample     <= '0;
		samples_ch.final_item <= 1'b0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single element set at the lowest value
		set_q = {MIN_SAMPLE};
		send_set(set_q);
		// two extremes out of order
		set_q = {MAX_SAMPLE, MIN_SAMPLE};
		send_set(set_q);
		// equal values are not inversions, order stays stable
		set_q = {sample_t'(-1), sample_t'(0), sample_t'(-1), sample_t'(0)};
		send_set(set_q);
		// fully reversed, every pair inverted
		set_q = {sample_t'(5), sample_t'(4), sample_t'(3), sample_t'(2),
			sample_t'(1), sample_t'(0), sample_t'(-1), sample_t'(-2)};
		send_set(set_q);
		// already sorted across the sign boundary
		set_q = {MIN_SAMPLE, sample_t'(-7), sample_t'(0), sample_t'(7), MAX_SAMPLE};
		send_set(set_q);
		// alternating bit patterns
		set_q = {sample_t'(32'h5555_5555), sample_t'(32'haaaa_aaaa), sample_t'(0)};
		send_set(set_q);

		// random sets: a full one and an overflowing one first, mostly small after
		sent      = 0;
		set_index = 0;
		while (sent < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 19);
			if (set_index == 0 || kind == 0)
				set_size = msic_pkg::MAX_ITEMS;
			else if (set_index == 1 || kind == 1)
				set_size = $urandom_range(msic_pkg::MAX_ITEMS + 1, msic_pkg::MAX_ITEMS + 6);
			else if (kind <= 4)
				set_size = $urandom_range(11, 40);
			else
				set_size = $urandom_range(1, 10);
			style = value_style_t'($urandom_range(0, 2));
			set_q.delete();
			repeat (set_size)
				set_q.push_back(draw_sample(style));
			send_set(set_q);
			sent += set_size;
			set_index++;
		end

		samples_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		// catch anything the block emits beyond the expected burst
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/msic_pkg.sv
hw/rtl/msic_if.sv
hw/rtl/msic_ram.sv
hw/rtl/merge_sort_inversion_count_unit.sv
hw/rtl/msic_checker.sv
bench/merge_sort_inversion_count_unit_test.sv
